// ===== rtl/tpspwm_pkg.sv =====
`timescale 1ns / 1ps

package tpspwm_pkg;

  // table and timing constants
  localparam int unsigned TABLE_LENGTH      = 192;
  localparam int unsigned TICK_BASE         = 200;
  localparam int unsigned FREQ_NUMERATOR    = 122070;
  localparam int unsigned FREQ_DIVISOR_BASE = 19200;

  localparam int unsigned ADDR_W  = $clog2(TABLE_LENGTH);
  localparam int unsigned ENTRY_W = 24;

  // shared divider widths
  localparam int unsigned DIV_NUM_W = 24;
  localparam int unsigned DIV_DEN_W = 16;

  localparam int unsigned FREQ_MAX     = 65535;
  localparam int unsigned AMP_LIMIT    = 2549;
  localparam int unsigned AMP_SAT      = 2550;
  localparam int unsigned MID_LEVEL    = 128;
  localparam int unsigned DECIMAL_BASE = 10;

  // divide by ten as (x * TENTH_MUL) >> TENTH_SHIFT, exact for 16-bit x
  localparam int unsigned TENTH_MUL   = 52429;
  localparam int unsigned TENTH_SHIFT = 19;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_INCREMENT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTS_PER_HERTZ = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_DEAD_BAND  = 2'd2;

  localparam logic [7:0] STEP_INCREMENT_RESET  = 8'd79;
  localparam logic [7:0] VOLTS_PER_HERTZ_RESET = 8'd45;
  localparam logic [6:0] HALF_DEAD_BAND_RESET  = 7'd20;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numerator;
    logic [DIV_DEN_W-1:0] denominator;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/tpspwm_if.sv =====
`timescale 1ns / 1ps

interface tpspwm_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       phase_swap;
  logic [7:0] entry_index;
  logic [7:0] first_phase_value;
  logic [7:0] second_phase_value;
  logic [7:0] third_phase_value;

  modport source (
    output valid, mode, phase_swap, entry_index,
           first_phase_value, second_phase_value, third_phase_value,
    input  ready
  );
  modport sink (
    input  valid, mode, phase_swap, entry_index,
           first_phase_value, second_phase_value, third_phase_value,
    output ready
  );
endinterface

interface tpspwm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] u_high_compare;
  logic [7:0] u_low_compare;
  logic [7:0] v_high_compare;
  logic [7:0] v_low_compare;
  logic [7:0] w_high_compare;
  logic [7:0] w_low_compare;

  modport source (
    output valid, u_high_compare, u_low_compare, v_high_compare,
           v_low_compare, w_high_compare, w_low_compare,
    input  ready
  );
  modport sink (
    input  valid, u_high_compare, u_low_compare, v_high_compare,
           v_low_compare, w_high_compare, w_low_compare,
    output ready
  );
endinterface

// ===== rtl/tpspwm_ram.sv =====
`timescale 1ns / 1ps

module tpspwm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tpspwm_div.sv =====
`timescale 1ns / 1ps

module tpspwm_div (
  input  logic                clk,
  input  logic                rst,
  input  tpspwm_pkg::div_req_t req,
  output tpspwm_pkg::div_rsp_t rsp
);

  localparam int unsigned NUM_W = tpspwm_pkg::DIV_NUM_W;
  localparam int unsigned DEN_W = tpspwm_pkg::DIV_DEN_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
        rem   <= '0;
        den   <= req.denominator;
        quo   <= req.numerator;
      end else if (busy) begin
        if (!diff[DEN_W]) begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/three_phase_sine_pwm_deadband_unit.sv =====
`timescale 1ns / 1ps

// channel   role    payload
// --------  ------  -----------------------------------------------------------
// item      sink    mode, phase_swap, entry_index, three phase bytes
// result    source  u/v/w high and low compare values, one word per tick
// cfg       write   cfg_write, cfg_index, cfg_data (step, V/Hz, half dead band)
//
// a table write goes into the table RAM when its item is taken; a tick passes
// through the table read, the scale multiply and the dead band, and its word
// is loaded into the output register from S_SPLIT once that register is free.
// every TICK_BASE ticks the amplitude is recomputed: two bit-serial divisions,
// then the two divides by ten with the V/Hz multiply between them, while item
// is held off.
// the output register holds a word while result is stalled; the next item
// is taken meanwhile. rst is synchronous, clears control state only and
// holds item off.

module three_phase_sine_pwm_deadband_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tpspwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tpspwm_pkg::CFG_DATA_W-1:0]     cfg_data,
  tpspwm_item_if.sink                           item,
  tpspwm_result_if.source                       result
);

  localparam int unsigned ADDR_W = tpspwm_pkg::ADDR_W;
  localparam int unsigned NUM_W  = tpspwm_pkg::DIV_NUM_W;
  localparam int unsigned DEN_W  = tpspwm_pkg::DIV_DEN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SPLIT,
    S_Q_START,
    S_Q_WAIT,
    S_F_START,
    S_F_WAIT,
    S_TENTH,
    S_A_MUL,
    S_A_DIV
  } state_t;

  typedef struct packed {
    logic [7:0] u_hi;
    logic [7:0] u_lo;
    logic [7:0] v_hi;
    logic [7:0] v_lo;
    logic [7:0] w_hi;
    logic [7:0] w_lo;
  } result_t;

  state_t state;

  // configuration
  logic [7:0] step_increment;
  logic [7:0] volts_per_hertz;
  logic [6:0] half_dead_band;

  // tick path
  logic [15:0] phase_acc;
  logic [15:0] phase_acc_next;
  logic [15:0] acc_sum;
  logic [7:0]  tick_count;
  logic [7:0]  tick_count_next;
  logic [7:0]  amplitude;
  logic        reverse;
  logic [15:0] prod_u;
  logic [15:0] prod_v;
  logic [15:0] prod_w;

  // amplitude update
  logic [7:0]  step_snap;
  logic [7:0]  vph_snap;
  logic [15:0] quot_q;
  logic [15:0] freq;
  logic [12:0] freq_tenth;
  logic [20:0] amp_product;
  logic [11:0] amp_scaled;
  logic [15:0] tenth_op;
  logic [31:0] tenth_prod;

  logic    out_valid;
  logic    out_load;
  result_t out_word;
  result_t split_word;

  logic                                 item_take;
  logic                                 table_we;
  logic [tpspwm_pkg::ENTRY_W-1:0]       table_rdata;
  tpspwm_pkg::div_req_t                 div_req;
  tpspwm_pkg::div_rsp_t                 div_rsp;

  function automatic logic [15:0] dead_band(input logic [7:0] c, input logic [6:0] d);
    logic [7:0] hi;
    logic [7:0] lo;
    if (c <= {1'b0, d}) begin
      hi = 8'd0;
      lo = c;
    end else if (c >= 8'd255 - {1'b0, d}) begin
      hi = 8'd255 - {d, 1'b0};
      lo = 8'd255;
    end else begin
      hi = c - {1'b0, d};
      lo = c + {1'b0, d};
    end
    return {hi, lo};
  endfunction

  function automatic logic [7:0] scale_level(input logic [15:0] prod);
    return 8'(tpspwm_pkg::MID_LEVEL) - {1'b0, prod[15:9]};
  endfunction

  assign item.ready = (state == S_IDLE) && !rst;
  assign item_take  = item.valid && item.ready;
  assign table_we   = item_take && item.mode &&
                      (item.entry_index < 8'(tpspwm_pkg::TABLE_LENGTH));

  // accumulator step with one wrap at the table length
  assign acc_sum = phase_acc + {8'b0, step_increment};
  always_comb begin
    phase_acc_next = acc_sum;
    if (acc_sum[15:8] >= 8'(tpspwm_pkg::TABLE_LENGTH)) begin
      phase_acc_next = acc_sum - 16'(tpspwm_pkg::TABLE_LENGTH << 8);
    end
  end

  assign tick_count_next = tick_count + 8'd1;

  tpspwm_ram #(
    .WIDTH (tpspwm_pkg::ENTRY_W),
    .DEPTH (tpspwm_pkg::TABLE_LENGTH)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (item.entry_index[ADDR_W-1:0]),
    .wdata ({item.third_phase_value, item.second_phase_value, item.first_phase_value}),
    .raddr (phase_acc_next[8 +: ADDR_W]),
    .rdata (table_rdata)
  );

  always_comb begin
    split_word = '0;
    {split_word.u_hi, split_word.u_lo} = dead_band(scale_level(prod_u), half_dead_band);
    {split_word.v_hi, split_word.v_lo} = dead_band(scale_level(prod_v), half_dead_band);
    {split_word.w_hi, split_word.w_lo} = dead_band(scale_level(prod_w), half_dead_band);
  end

  assign out_load = (state == S_SPLIT) && (!out_valid || result.ready);

  // divider operand select
  always_comb begin
    div_req = '0;
    unique case (state)
      S_Q_START: begin
        div_req.start       = (step_snap != 8'd0);
        div_req.numerator   = NUM_W'(tpspwm_pkg::FREQ_DIVISOR_BASE);
        div_req.denominator = {8'b0, step_snap};
      end
      S_F_START: begin
        div_req.start       = (quot_q != 16'd0);
        div_req.numerator   = NUM_W'(tpspwm_pkg::FREQ_NUMERATOR);
        div_req.denominator = DEN_W'(quot_q);
      end
      default: ;
    endcase
  end

  tpspwm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // one reciprocal multiplier serves both divides by ten
  assign tenth_op    = (state == S_TENTH) ? freq : {4'b0, amp_scaled};
  assign tenth_prod  = {16'b0, tenth_op} * 32'(tpspwm_pkg::TENTH_MUL);
  assign amp_product = 21'(freq_tenth) * 21'(vph_snap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step_increment  <= tpspwm_pkg::STEP_INCREMENT_RESET;
      volts_per_hertz <= tpspwm_pkg::VOLTS_PER_HERTZ_RESET;
      half_dead_band  <= tpspwm_pkg::HALF_DEAD_BAND_RESET;
      phase_acc       <= '0;
      tick_count      <= '0;
      amplitude       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          tpspwm_pkg::REG_STEP_INCREMENT:  step_increment  <= cfg_data[7:0];
          tpspwm_pkg::REG_VOLTS_PER_HERTZ: volts_per_hertz <= cfg_data[7:0];
          tpspwm_pkg::REG_HALF_DEAD_BAND:  half_dead_band  <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_take && !item.mode) begin
            phase_acc <= phase_acc_next;
            reverse   <= item.phase_swap;
            state     <= S_READ;
          end
        end
        S_READ: begin
          prod_u <= 16'(amplitude) * 16'(table_rdata[7:0]);
          if (reverse) begin
            prod_v <= 16'(amplitude) * 16'(table_rdata[15:8]);
            prod_w <= 16'(amplitude) * 16'(table_rdata[23:16]);
          end else begin
            prod_w <= 16'(amplitude) * 16'(table_rdata[15:8]);
            prod_v <= 16'(amplitude) * 16'(table_rdata[23:16]);
          end
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          // wait for the output register to free up
          if (out_load) begin
            out_word  <= split_word;
            step_snap <= step_increment;
            vph_snap  <= volts_per_hertz;
            if (tick_count_next >= 8'(tpspwm_pkg::TICK_BASE)) begin
              tick_count <= '0;
              state      <= S_Q_START;
            end else begin
              tick_count <= tick_count_next;
              state      <= S_IDLE;
            end
          end
        end
        S_Q_START: begin
          if (step_snap == 8'd0) begin
            amplitude <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_Q_WAIT;
          end
        end
        S_Q_WAIT: begin
          if (div_rsp.done) begin
            quot_q <= div_rsp.quotient[15:0];
            state  <= S_F_START;
          end
        end
        S_F_START: begin
          if (quot_q == 16'd0) begin
            freq  <= 16'(tpspwm_pkg::FREQ_MAX);
            state <= S_TENTH;
          end else begin
            state <= S_F_WAIT;
          end
        end
        S_F_WAIT: begin
          if (div_rsp.done) begin
            if (|div_rsp.quotient[tpspwm_pkg::DIV_NUM_W-1:16]) begin
              freq <= 16'(tpspwm_pkg::FREQ_MAX);
            end else begin
              freq <= div_rsp.quotient[15:0];
            end
            state <= S_TENTH;
          end
        end
        S_TENTH: begin
          freq_tenth <= tenth_prod[tpspwm_pkg::TENTH_SHIFT +: 13];
          state      <= S_A_MUL;
        end
        S_A_MUL: begin
          if (amp_product > 21'(tpspwm_pkg::AMP_LIMIT)) begin
            amp_scaled <= 12'(tpspwm_pkg::AMP_SAT);
          end else begin
            amp_scaled <= amp_product[11:0];
          end
          state <= S_A_DIV;
        end
        S_A_DIV: begin
          amplitude <= tenth_prod[tpspwm_pkg::TENTH_SHIFT +: 8];
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.u_high_compare = out_word.u_hi;
  assign result.u_low_compare  = out_word.u_lo;
  assign result.v_high_compare = out_word.v_hi;
  assign result.v_low_compare  = out_word.v_lo;
  assign result.w_high_compare = out_word.w_hi;
  assign result.w_low_compare  = out_word.w_lo;

endmodule
